>>> rtl/multilevel_queue_sjf_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multilevel queue scheduler
// Shared shorthand for the concurrent checks written in the RTL.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_QUEUE_SJF_SCHEDULER_UNIT_DEFINES_SVH
`define MULTILEVEL_QUEUE_SJF_SCHEDULER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MLQS_ASSERT_ALWAYS(label, clk_s, rst_s, cond, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
		else $error(msg);

// An antecedent that, when true, requires the consequent in the same cycle.
`define MLQS_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/mlqs_pkg.sv
// ----------------------------------------------------------------------------
// Multilevel queue scheduler package
// Sizes, beat types, status codes and slot arithmetic shared by the RTL.
// ----------------------------------------------------------------------------
package mlqs_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int TAG_BITS    = 8;
	localparam int BURST_BITS  = 16;
	localparam int NUM_LEVELS  = 4;
	localparam int LVL_W       = 2;
	localparam int LEVEL_IN_W  = 3;
	localparam int STATUS_W    = 3;

	localparam int ENTRY_W = TAG_BITS + BURST_BITS;
	localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

	// Level whose queue is kept ordered by burst length.
	localparam logic [LVL_W-1:0] SORTED_LEVEL = 2'd1;

	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

	typedef struct packed {
		logic                  action;
		logic [TAG_BITS-1:0]   process_tag;
		logic [LEVEL_IN_W-1:0] queue_level;
		logic [BURST_BITS-1:0] burst_length;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [TAG_BITS-1:0]   out_tag;
		logic [BURST_BITS-1:0] out_burst;
		logic [LVL_W-1:0]      out_level;
	} rsp_item_t;

	// Circular slot addition: both operands are below the depth, so one
	// conditional subtract wraps the sum.
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
			input logic [SLOT_W-1:0] offs);
		logic [SLOT_W:0] sum;
		sum = {1'b0, base} + {1'b0, offs};
		if (sum >= (SLOT_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (SLOT_W + 1)'(QUEUE_DEPTH);
		end
		return sum[SLOT_W-1:0];
	endfunction

endpackage

>>> rtl/multilevel_queue_sjf_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Multilevel queue scheduler with shortest-burst ordering on level 1
// Four circular queues in RAM; levels 0, 2 and 3 are first-come, level 1 is
// kept sorted by burst length with a one-entry-per-cycle insertion walk.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake        | Beat type
//  --------+-----------+------------------+----------------------
//  req     | in        | req_valid/stall  | mlqs_pkg::req_item_t
//  rsp     | out       | rsp_valid/stall  | mlqs_pkg::rsp_item_t
//
// An enqueue to level 0, 2 or 3, an enqueue to an empty level 1, a rejected
// enqueue and an empty dequeue go from the accepted beat through S_EVAL and
// S_DONE to the output register; a dequeue also passes through S_DEQ, since
// the queue RAM read is registered.
// An enqueue to a non-empty level 1 walks in S_SHIFT, stepping back once per
// waiting entry with a longer burst: the walk does one RAM read, one compare
// and one move per cycle on the level 1 RAM port.
// The sequencer returns to idle as the output register loads and takes the
// next beat only from there, so it finishes one item before it accepts another.
// Reset clears the fill counts, head pointers, sequencer state and output valid;
// the queue RAMs need no clearing, since only counted entries are ever read.
// req_stall is low only while the sequencer is idle. A result waiting in the
// output register does not block the next beat; it only holds the sequencer
// in its final state until the register frees up.
// ----------------------------------------------------------------------------
`include "multilevel_queue_sjf_scheduler_unit_defines.svh"

module multilevel_queue_sjf_scheduler_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mlqs_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output mlqs_pkg::rsp_item_t rsp
);

	// Sequencer states:
	//   S_IDLE  waiting for a request beat
	//   S_EVAL  decide the action, issue the first RAM access
	//   S_SHIFT level 1 insertion walk, one entry examined per cycle
	//   S_PLACE write the new entry at the head slot of level 1
	//   S_DEQ   pick up the registered RAM read of a dequeue
	//   S_DONE  hand the result to the output register
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EVAL  = 6'b000010,
		S_SHIFT = 6'b000100,
		S_PLACE = 6'b001000,
		S_DEQ   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	mlqs_pkg::req_item_t req_q;
	mlqs_pkg::rsp_item_t res_q, res_d;
	mlqs_pkg::rsp_item_t rsp_q;
	logic                rsp_valid_q;
	logic                rsp_load;

	// Per-level bookkeeping: fill counts and head pointers.
	logic [mlqs_pkg::CNT_W-1:0]  fill_q [mlqs_pkg::NUM_LEVELS];
	logic [mlqs_pkg::CNT_W-1:0]  fill_d [mlqs_pkg::NUM_LEVELS];
	logic [mlqs_pkg::SLOT_W-1:0] head_q [mlqs_pkg::NUM_LEVELS];
	logic [mlqs_pkg::SLOT_W-1:0] head_d [mlqs_pkg::NUM_LEVELS];

	// Insertion walk position and the level being worked on.
	logic [mlqs_pkg::SLOT_W-1:0] idx_q, idx_d;
	logic [mlqs_pkg::LVL_W-1:0]  lvl_q, lvl_d;

	// Queue RAM ports, one RAM per level sharing the address buses.
	logic [mlqs_pkg::NUM_LEVELS-1:0] wr_en;
	logic [mlqs_pkg::SLOT_W-1:0]     wr_addr;
	logic [mlqs_pkg::ENTRY_W-1:0]    wr_data;
	logic [mlqs_pkg::NUM_LEVELS-1:0] rd_en;
	logic [mlqs_pkg::SLOT_W-1:0]     rd_addr;
	logic [mlqs_pkg::ENTRY_W-1:0]    rd_data [mlqs_pkg::NUM_LEVELS];

	logic [mlqs_pkg::ENTRY_W-1:0] new_entry;
	logic [mlqs_pkg::ENTRY_W-1:0] sorted_word;
	logic [mlqs_pkg::ENTRY_W-1:0] deq_word;
	logic [mlqs_pkg::LVL_W-1:0]   req_lvl;
	logic                         deq_found;
	logic [mlqs_pkg::LVL_W-1:0]   deq_lvl;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign new_entry   = {req_q.process_tag, req_q.burst_length};
	assign req_lvl     = req_q.queue_level[mlqs_pkg::LVL_W-1:0];
	assign sorted_word = rd_data[mlqs_pkg::SORTED_LEVEL];
	assign deq_word    = rd_data[lvl_q];
	assign wr_data     = (state_q == S_SHIFT && wr_en != '0 &&
			req_q.burst_length < sorted_word[mlqs_pkg::BURST_BITS-1:0]) ?
			sorted_word : new_entry;

	genvar g;
	generate
		for (g = 0; g < mlqs_pkg::NUM_LEVELS; g++) begin : g_level_ram
			mlqs_ram #(
				.WIDTH (mlqs_pkg::ENTRY_W),
				.DEPTH (mlqs_pkg::QUEUE_DEPTH)
			) u_ram (
				.clk     (clk),
				.wr_en   (wr_en[g]),
				.wr_addr (wr_addr),
				.wr_data (wr_data),
				.rd_en   (rd_en[g]),
				.rd_addr (rd_addr),
				.rd_data (rd_data[g])
			);
		end
	endgenerate

	// The lowest-numbered level that holds anything wins a dequeue. The loop
	// runs from the top level down so the last hit is the lowest level.
	always_comb begin
		deq_found = 1'b0;
		deq_lvl   = '0;
		for (int lv = mlqs_pkg::NUM_LEVELS - 1; lv >= 0; lv--) begin
			if (fill_q[lv] != '0) begin
				deq_found = 1'b1;
				deq_lvl   = mlqs_pkg::LVL_W'(lv);
			end
		end
	end

	// Sequencer. The insertion walk on level 1 compares the new burst with the
	// entry one slot back; a longer burst moves up one slot and the walk steps
	// back, otherwise the new entry lands in the freed slot. Equal bursts stop
	// the walk, which keeps arrival order among them.
	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		head_d   = head_q;
		idx_d    = idx_q;
		lvl_d    = lvl_q;
		res_d    = res_q;
		wr_en    = '0;
		wr_addr  = '0;
		rd_en    = '0;
		rd_addr  = '0;
		rsp_load = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EVAL;
				end
			end

			S_EVAL: begin
				res_d = '0;
				if (req_q.action == mlqs_pkg::ACT_DEQUEUE) begin
					if (!deq_found) begin
						res_d.status = mlqs_pkg::ST_EMPTY;
						state_d      = S_DONE;
					end else begin
						rd_en[deq_lvl]  = 1'b1;
						rd_addr         = head_q[deq_lvl];
						head_d[deq_lvl] = mlqs_pkg::slot_add(head_q[deq_lvl],
								mlqs_pkg::SLOT_W'(1));
						fill_d[deq_lvl] = fill_q[deq_lvl] - mlqs_pkg::CNT_W'(1);
						lvl_d           = deq_lvl;
						state_d         = S_DEQ;
					end
				end else if (req_q.queue_level[mlqs_pkg::LEVEL_IN_W-1]) begin
					res_d.status = mlqs_pkg::ST_BAD_LEVEL;
					state_d      = S_DONE;
				end else if (fill_q[req_lvl] == mlqs_pkg::CNT_W'(mlqs_pkg::QUEUE_DEPTH)) begin
					res_d.status    = mlqs_pkg::ST_FULL;
					res_d.out_level = req_lvl;
					state_d         = S_DONE;
				end else if (req_lvl == mlqs_pkg::SORTED_LEVEL && fill_q[req_lvl] != '0) begin
					// Start the walk at the tail entry.
					rd_en[req_lvl] = 1'b1;
					rd_addr        = mlqs_pkg::slot_add(head_q[req_lvl],
							mlqs_pkg::SLOT_W'(fill_q[req_lvl] - mlqs_pkg::CNT_W'(1)));
					idx_d          = mlqs_pkg::SLOT_W'(fill_q[req_lvl]);
					lvl_d          = req_lvl;
					state_d        = S_SHIFT;
				end else begin
					wr_en[req_lvl]  = 1'b1;
					wr_addr         = mlqs_pkg::slot_add(head_q[req_lvl],
							mlqs_pkg::SLOT_W'(fill_q[req_lvl]));
					fill_d[req_lvl] = fill_q[req_lvl] + mlqs_pkg::CNT_W'(1);
					res_d.status    = mlqs_pkg::ST_ENQUEUED;
					res_d.out_level = req_lvl;
					state_d         = S_DONE;
				end
			end

			S_SHIFT: begin
				wr_en[mlqs_pkg::SORTED_LEVEL] = 1'b1;
				wr_addr = mlqs_pkg::slot_add(head_q[mlqs_pkg::SORTED_LEVEL], idx_q);
				if (req_q.burst_length < sorted_word[mlqs_pkg::BURST_BITS-1:0]) begin
					// Entry one back moves up into this slot.
					idx_d = idx_q - mlqs_pkg::SLOT_W'(1);
					if (idx_q == mlqs_pkg::SLOT_W'(1)) begin
						state_d = S_PLACE;
					end else begin
						rd_en[mlqs_pkg::SORTED_LEVEL] = 1'b1;
						rd_addr = mlqs_pkg::slot_add(head_q[mlqs_pkg::SORTED_LEVEL],
								idx_q - mlqs_pkg::SLOT_W'(2));
					end
				end else begin
					fill_d[mlqs_pkg::SORTED_LEVEL] = fill_q[mlqs_pkg::SORTED_LEVEL] +
							mlqs_pkg::CNT_W'(1);
					res_d.status    = mlqs_pkg::ST_ENQUEUED;
					res_d.out_level = mlqs_pkg::SORTED_LEVEL;
					state_d         = S_DONE;
				end
			end

			S_PLACE: begin
				wr_en[mlqs_pkg::SORTED_LEVEL] = 1'b1;
				wr_addr = mlqs_pkg::slot_add(head_q[mlqs_pkg::SORTED_LEVEL], idx_q);
				fill_d[mlqs_pkg::SORTED_LEVEL] = fill_q[mlqs_pkg::SORTED_LEVEL] +
						mlqs_pkg::CNT_W'(1);
				res_d.status    = mlqs_pkg::ST_ENQUEUED;
				res_d.out_level = mlqs_pkg::SORTED_LEVEL;
				state_d         = S_DONE;
			end

			S_DEQ: begin
				res_d.status    = mlqs_pkg::ST_DEQUEUED;
				res_d.out_tag   = deq_word[mlqs_pkg::ENTRY_W-1:mlqs_pkg::BURST_BITS];
				res_d.out_burst = deq_word[mlqs_pkg::BURST_BITS-1:0];
				res_d.out_level = lvl_q;
				state_d         = S_DONE;
			end

			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int lv = 0; lv < mlqs_pkg::NUM_LEVELS; lv++) begin
				fill_q[lv] <= '0;
				head_q[lv] <= '0;
			end
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			head_q  <= head_d;
		end
	end

	// Working registers, left without reset.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q <= req;
		end
		idx_q <= idx_d;
		lvl_q <= lvl_d;
		res_q <= res_d;
	end

	// Output register: loaded from the sequencer, emptied when the beat goes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	// No level may ever count more entries than its RAM holds.
	`MLQS_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, (fill_q[0] <= mlqs_pkg::CNT_W'(mlqs_pkg::QUEUE_DEPTH)) && (fill_q[1] <= mlqs_pkg::CNT_W'(mlqs_pkg::QUEUE_DEPTH)) && (fill_q[2] <= mlqs_pkg::CNT_W'(mlqs_pkg::QUEUE_DEPTH)) && (fill_q[3] <= mlqs_pkg::CNT_W'(mlqs_pkg::QUEUE_DEPTH)), "fill count above queue depth")

	// The insertion walk always has a slot below it to look at.
	`MLQS_ASSERT_IMPLIES(a_walk_index, clk, arst_n, state_q == S_SHIFT, idx_q != '0, "insertion walk at index zero")

	// At most one queue RAM is written in any cycle.
	`MLQS_ASSERT_ALWAYS(a_one_write, clk, arst_n, $onehot0(wr_en), "several queue RAMs written at once")

	// A result appears only after the sequencer has finished an item.
	`MLQS_ASSERT_IMPLIES(a_result_source, clk, arst_n, $rose(rsp_valid_q), $past(state_q == S_DONE), "result beat without a finished item")

endmodule

>>> rtl/mlqs_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mlqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds between reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> verif/tb_multilevel_queue_sjf_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multilevel queue scheduler
// Drives enqueue and dequeue beats through the request channel and checks
// every result beat against a behavioral copy of the four queues. Level 1 is
// modeled as a list ordered by burst length with ties kept in arrival order.
// Runs through phases with and without idling on either side.
// ----------------------------------------------------------------------------
module tb_multilevel_queue_sjf_scheduler_unit;
	import mlqs_pkg::*;

	// One waiting process as the scheduler stores it.
	typedef struct packed {
		logic [TAG_BITS-1:0]   tag;
		logic [BURST_BITS-1:0] burst;
	} waiting_proc_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	multilevel_queue_sjf_scheduler_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Request beats waiting to be driven, and result beats predicted for the
	// requests that the block has already accepted, oldest first.
	req_item_t pending_req[$];
	rsp_item_t expected_rsp[$];

	// Percent chance, per cycle, that the sender holds back a new beat and
	// that the receiver stalls. The stimulus process changes them per phase.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Set at a rising edge where the request beat was taken, so that the
	// driver knows at the next falling edge that it may present a new one.
	logic req_fire = 1'b0;

	int unsigned mismatch_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned status_seen[5];

	// Scheduler image: each level as a plain array with the head at index 0.
	// Dequeue shifts the array down; a level 1 enqueue shifts the longer
	// bursts up, so equal bursts stay behind the ones that came first.
	waiting_proc_t level_procs[NUM_LEVELS][QUEUE_DEPTH];
	int unsigned   level_fill[NUM_LEVELS];

	// Applies one accepted request to the scheduler image and returns the
	// result beat that it must produce.
	function automatic rsp_item_t schedule_step(input req_item_t it);
		rsp_item_t     r;
		int unsigned   lv;
		int unsigned   pos;
		int unsigned   k;
		waiting_proc_t fresh;
		r = '0;
		if (it.action == ACT_ENQUEUE) begin
			if (it.queue_level >= NUM_LEVELS) begin
				// A level beyond the last one is refused and reports level 0.
				r.status = ST_BAD_LEVEL;
			end else begin
				lv = it.queue_level;
				r.out_level = LVL_W'(lv);
				if (level_fill[lv] >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					fresh.tag = it.process_tag;
					fresh.burst = it.burst_length;
					pos = level_fill[lv];
					if (lv == SORTED_LEVEL) begin
						while (pos > 0 && fresh.burst < level_procs[lv][pos-1].burst) begin
							level_procs[lv][pos] = level_procs[lv][pos-1];
							pos--;
						end
					end
					level_procs[lv][pos] = fresh;
					level_fill[lv]++;
					r.status = ST_ENQUEUED;
				end
			end
		end else begin
			// The request fields of a dequeue carry no meaning.
			r.status = ST_EMPTY;
			for (lv = 0; lv < NUM_LEVELS; lv++) begin
				if (r.status == ST_EMPTY && level_fill[lv] != 0) begin
					r.status = ST_DEQUEUED;
					r.out_tag = level_procs[lv][0].tag;
					r.out_burst = level_procs[lv][0].burst;
					r.out_level = LVL_W'(lv);
					for (k = 1; k < level_fill[lv]; k++) begin
						level_procs[lv][k-1] = level_procs[lv][k];
					end
					level_fill[lv]--;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// Compares one accepted result beat with the oldest prediction.
	task automatic check_result(input rsp_item_t got);
		rsp_item_t want;
		if (expected_rsp.size() == 0) begin
			report_mismatch("unexpected result beat, status", 32'(got.status), 32'h0);
		end else begin
			want = expected_rsp.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 32'(got.status), 32'(want.status));
			if (got.out_tag !== want.out_tag)
				report_mismatch("out_tag", 32'(got.out_tag), 32'(want.out_tag));
			if (got.out_burst !== want.out_burst)
				report_mismatch("out_burst", 32'(got.out_burst), 32'(want.out_burst));
			if (got.out_level !== want.out_level)
				report_mismatch("out_level", 32'(got.out_level), 32'(want.out_level));
			if (want.status <= ST_EMPTY)
				status_seen[want.status]++;
		end
	endtask

	// Driver: everything changes at the falling edge. A beat stays on the bus
	// unchanged until the block takes it; only then is the next one chosen.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_fire) begin
				if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= pending_req[0];
					pending_req.delete(0);
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: samples both channels at the rising edge. The result check
	// runs before the new prediction is queued, though a result never belongs
	// to a request taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				check_result(rsp);
			if (req_valid && !req_stall) begin
				expected_rsp.push_back(schedule_step(req));
				accepted_cnt++;
			end
			req_fire <= req_valid && !req_stall;
		end
	end

	function automatic req_item_t make_req(input logic act, input logic [TAG_BITS-1:0] tag,
			input logic [LEVEL_IN_W-1:0] lvl, input logic [BURST_BITS-1:0] burst);
		req_item_t it;
		it.action = act;
		it.process_tag = tag;
		it.queue_level = lvl;
		it.burst_length = burst;
		return it;
	endfunction

	// Burst lengths drawn half the time from a few values, so that level 1
	// sees many equal keys, and otherwise from the whole range.
	function automatic logic [BURST_BITS-1:0] pick_burst();
		if ($urandom_range(1) == 0)
			return BURST_BITS'($urandom);
		case ($urandom_range(4))
			0: return '0;
			1: return BURST_BITS'(1);
			2: return BURST_BITS'(7);
			3: return BURST_BITS'(8);
			default: return '1;
		endcase
	endfunction

	// A random beat: mostly enqueues to valid levels, some refused levels,
	// and dequeues with junk in the ignored fields.
	function automatic req_item_t random_req();
		logic [LEVEL_IN_W-1:0] lvl;
		if ($urandom_range(99) < 40)
			return make_req(ACT_DEQUEUE, TAG_BITS'($urandom), LEVEL_IN_W'($urandom),
				BURST_BITS'($urandom));
		if ($urandom_range(99) < 15)
			lvl = LEVEL_IN_W'($urandom_range(7, NUM_LEVELS));
		else
			lvl = LEVEL_IN_W'($urandom_range(NUM_LEVELS - 1));
		return make_req(ACT_ENQUEUE, TAG_BITS'($urandom), lvl, pick_burst());
	endfunction

	// Pushes enough enqueues to one level to fill it and bounce off the top.
	task automatic fill_level(input int unsigned lv);
		int unsigned n;
		for (n = 0; n < QUEUE_DEPTH + 1; n++)
			pending_req.push_back(make_req(ACT_ENQUEUE, TAG_BITS'($urandom),
				LEVEL_IN_W'(lv), pick_burst()));
	endtask

	task automatic push_dequeues(input int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++)
			pending_req.push_back(make_req(ACT_DEQUEUE, TAG_BITS'($urandom),
				LEVEL_IN_W'($urandom), BURST_BITS'($urandom)));
	endtask

	task automatic push_random(input int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++)
			pending_req.push_back(random_req());
	endtask

	// Holds back new stimulus until every queued beat is taken and every
	// predicted result has come back.
	task automatic wait_drained();
		while (pending_req.size() != 0 || expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned lv;
		for (lv = 0; lv < NUM_LEVELS; lv++)
			level_fill[lv] = 0;
		for (lv = 0; lv < 5; lv++)
			status_seen[lv] = 0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed opening with no idling. A dequeue from an empty scheduler,
		// refused levels at both ends, extreme tags and bursts on level 0,
		// and level 1 entries out of order with repeated bursts. Then dequeues
		// with junk fields until everything is out, and one past that.
		pending_req.push_back(make_req(ACT_DEQUEUE, '1, '1, '1));
		pending_req.push_back(make_req(ACT_ENQUEUE, '1, LEVEL_IN_W'(NUM_LEVELS), '1));
		pending_req.push_back(make_req(ACT_ENQUEUE, '0, '1, '0));
		pending_req.push_back(make_req(ACT_ENQUEUE, '0, LEVEL_IN_W'(0), '0));
		pending_req.push_back(make_req(ACT_ENQUEUE, '1, LEVEL_IN_W'(0), '1));
		pending_req.push_back(make_req(ACT_ENQUEUE, 8'h5a, LEVEL_IN_W'(2), 16'h1234));
		pending_req.push_back(make_req(ACT_ENQUEUE, 8'ha5, LEVEL_IN_W'(3), 16'hedcb));
		pending_req.push_back(make_req(ACT_ENQUEUE, 8'h11, {1'b0, SORTED_LEVEL}, 16'd500));
		pending_req.push_back(make_req(ACT_ENQUEUE, 8'h12, {1'b0, SORTED_LEVEL}, 16'd100));
		pending_req.push_back(make_req(ACT_ENQUEUE, 8'h13, {1'b0, SORTED_LEVEL}, 16'd500));
		pending_req.push_back(make_req(ACT_ENQUEUE, 8'h14, {1'b0, SORTED_LEVEL}, 16'd0));
		pending_req.push_back(make_req(ACT_ENQUEUE, 8'h15, {1'b0, SORTED_LEVEL}, 16'hffff));
		pending_req.push_back(make_req(ACT_ENQUEUE, 8'h16, {1'b0, SORTED_LEVEL}, 16'd100));
		push_dequeues(11);
		wait_drained();

		push_random(60);
		wait_drained();

		// Sender mostly idle: take level 1 to full with many tied bursts,
		// then empty it again through the priority order.
		send_idle_pct = 83;
		fill_level(SORTED_LEVEL);
		push_dequeues(QUEUE_DEPTH + 3);
		wait_drained();

		// Receiver stalling most of the time.
		send_idle_pct = 0;
		recv_stall_pct = 83;
		push_random(60);
		wait_drained();

		// Light idling on both sides while one first-come level fills up.
		send_idle_pct = 6;
		recv_stall_pct = 6;
		case ($urandom_range(2))
			0: fill_level(0);
			1: fill_level(2);
			default: fill_level(3);
		endcase
		push_dequeues(QUEUE_DEPTH + 6);
		wait_drained();

		// A closing stretch at full rate.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		push_random(30);
		wait_drained();

		// Longest walk is a level 1 insert past a queue one short of full; allow
		// for it and watch for any stray result beat.
		repeat (QUEUE_DEPTH + 16) @(posedge clk);
		if (expected_rsp.size() != 0)
			report_mismatch("results still missing, count", expected_rsp.size(), 0);

		$display("Run covered %0d request beats: %0d enqueued, %0d refused as full,",
			accepted_cnt, status_seen[ST_ENQUEUED], status_seen[ST_FULL]);
		$display("  %0d refused for level, %0d dequeued, %0d found all queues empty.",
			status_seen[ST_BAD_LEVEL], status_seen[ST_DEQUEUED], status_seen[ST_EMPTY]);
		if (mismatch_cnt == 0) begin
			$display("tb_multilevel_queue_sjf_scheduler_unit: clean");
		end else begin
			$display("tb_multilevel_queue_sjf_scheduler_unit: errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("Timeout with %0d beats pending and %0d results outstanding.",
			pending_req.size(), expected_rsp.size());
		$display("tb_multilevel_queue_sjf_scheduler_unit: errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/mlqs_pkg.sv
rtl/mlqs_ram.sv
rtl/multilevel_queue_sjf_scheduler_unit.sv
verif/tb_multilevel_queue_sjf_scheduler_unit.sv
